>>> src/tile_sprite_pixel_compositor_defines.svh
// Assertion macros for the tile and sprite pixel compositor.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TILE_SPRITE_PIXEL_COMPOSITOR_DEFINES_SVH
`define TILE_SPRITE_PIXEL_COMPOSITOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TSPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define TSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define TSPC_ASSERT_SAME(label, clk, rst, ante, cons)
`define TSPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/tspc_pkg.sv
// Shared types and constants of the tile and sprite pixel compositor.
// No dependencies.
package tspc_pkg;

  localparam int MEM_WORDS    = 65536;
  localparam int MEM_AW       = $clog2(MEM_WORDS);
  localparam int SCREEN_W     = 320;
  localparam int SCREEN_H     = 240;
  localparam int GRID_COLS    = 41;
  localparam int GRID_ROWS    = 31;
  localparam int SPRITE_COUNT = 256;
  localparam int SPR_W        = $clog2(SPRITE_COUNT);
  localparam int GRID_PIX_W   = GRID_COLS * 8;
  localparam int GRID_PIX_H   = GRID_ROWS * 8;

  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  // read address sources
  localparam logic [1:0] ASEL_CELL  = 2'd0;
  localparam logic [1:0] ASEL_GTILE = 2'd1;
  localparam logic [1:0] ASEL_SENT  = 2'd2;
  localparam logic [1:0] ASEL_SPIX  = 2'd3;

  // sprite entry word offsets
  localparam logic [1:0] ENT_STATUS = 2'd0;
  localparam logic [1:0] ENT_TILE   = 2'd1;
  localparam logic [1:0] ENT_X      = 2'd2;
  localparam logic [1:0] ENT_Y      = 2'd3;

  // register indexes
  localparam logic [2:0] REG_CLEAR   = 3'd0;
  localparam logic [2:0] REG_GBASE   = 3'd1;
  localparam logic [2:0] REG_GSKIP   = 3'd2;
  localparam logic [2:0] REG_GTILE   = 3'd3;
  localparam logic [2:0] REG_STABLE  = 3'd4;
  localparam logic [2:0] REG_STILE   = 3'd5;
  localparam logic [2:0] REG_SCROLLX = 3'd6;
  localparam logic [2:0] REG_SCROLLY = 3'd7;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [15:0] address;
    logic [31:0] write_data;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] color;
    logic [8:0]  out_x;
    logic [7:0]  out_y;
  } out_item_t;

  typedef struct packed {
    logic [31:0] clear_color;
    logic [15:0] grid_base;
    logic [15:0] grid_row_skip;
    logic [15:0] grid_tile_base;
    logic [15:0] sprite_table_base;
    logic [15:0] sprite_tile_base;
    logic [31:0] scroll_x;
    logic [31:0] scroll_y;
  } cfg_t;

  typedef struct packed {
    logic       wr_en;
    logic       start;
    logic       mul;
    logic       rd_en;
    logic [1:0] asel;
    logic [1:0] ent;
    logic       front;
    logic       cap_status;
    logic       cap_tile;
    logic       cap_x;
    logic       cap_y;
    logic       cap_pix;
    logic       apply;
    logic       spr_clr;
    logic       spr_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic offscreen;
    logic grid_ok;
    logic cell_ok;
    logic spr_en;
    logic spr_hit;
    logic spr_last;
  } stat_t;

endpackage

>>> src/tile_sprite_pixel_compositor.sv
// Top level of the tile and sprite pixel compositor: register file and glue.
// Depends on tspc_pkg, tspc_ctrl and tspc_datapath.
// A write item is accepted only while idle. A query runs the back grid pass, every sprite
// entry (disabled entries, enabled misses and hits take different paths) and the front
// grid pass, one read at a time on the single read port; off-screen queries skip the passes.
// Synchronous reset clears the registers and the sequencer; memory is not cleared.
module tile_sprite_pixel_compositor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tspc_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tspc_pkg::out_item_t   out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tspc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  // APB: no wait states; a register updates on the access phase of a write transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CLEAR:   cfg.clear_color       <= pwdata;
        REG_GBASE:   cfg.grid_base         <= pwdata[15:0];
        REG_GSKIP:   cfg.grid_row_skip     <= pwdata[15:0];
        REG_GTILE:   cfg.grid_tile_base    <= pwdata[15:0];
        REG_STABLE:  cfg.sprite_table_base <= pwdata[15:0];
        REG_STILE:   cfg.sprite_tile_base  <= pwdata[15:0];
        REG_SCROLLX: cfg.scroll_x          <= pwdata;
        REG_SCROLLY: cfg.scroll_y          <= pwdata;
        default: ;
      endcase
    end
  end

  // read back: narrow registers return zero in the upper half
  always_comb begin
    case (paddr[4:2])
      REG_CLEAR:   prdata = cfg.clear_color;
      REG_GBASE:   prdata = {16'd0, cfg.grid_base};
      REG_GSKIP:   prdata = {16'd0, cfg.grid_row_skip};
      REG_GTILE:   prdata = {16'd0, cfg.grid_tile_base};
      REG_STABLE:  prdata = {16'd0, cfg.sprite_table_base};
      REG_STILE:   prdata = {16'd0, cfg.sprite_tile_base};
      REG_SCROLLX: prdata = cfg.scroll_x;
      REG_SCROLLY: prdata = cfg.scroll_y;
      default:     prdata = '0;
    endcase
  end

  // sequencer: owns the handshakes and walks the painter order
  tspc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: memory, address generation, hit tests, accumulator, output register
  tspc_datapath u_dp (
    .clk      (clk),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );
endmodule

>>> src/tspc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module tspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/tspc_datapath.sv
// Datapath: word memory, position arithmetic, sprite fields and color accumulator.
// Depends on tspc_pkg and tspc_ram.
module tspc_datapath (
  input  logic              clk,
  input  tspc_pkg::cfg_t     cfg,
  input  tspc_pkg::in_item_t in_item,
  input  tspc_pkg::cmd_t     cmd,
  output tspc_pkg::stat_t    stat,
  output tspc_pkg::out_item_t out_item
);
  import tspc_pkg::*;

  logic [8:0]  px;
  logic [7:0]  py;
  logic [33:0] gx;
  logic [33:0] gy;
  logic        offscreen;
  logic [31:0] acc;
  logic [15:0] cell_ofs;
  logic [SPR_W-1:0] spr;
  logic [3:0]  wn;
  logic [3:0]  hn;
  logic        hflip;
  logic        vflip;
  logic [8:0]  wh;
  logic [9:0]  tile_lo;
  logic [34:0] lx;
  logic [34:0] ly;
  logic [9:0]  pix_prod;
  logic [11:0] row_ofs;
  logic [6:0]  col;
  logic [6:0]  col_c;
  logic [6:0]  row_c;
  logic [31:0] rd_data;
  logic [15:0] raddr;
  logic [21:0] cell_mul;
  logic [17:0] prod_full;
  logic [11:0] row_mul;
  logic [34:0] sx_ext;

  tspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (in_item.address[MEM_AW-1:0]),
    .wdata (in_item.write_data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    case (cmd.asel)
      ASEL_CELL:  raddr = cfg.grid_base + cell_ofs + {10'd0, gx[8:3]};
      ASEL_GTILE: raddr = cfg.grid_tile_base + {rd_data[9:0], 6'd0} +
                          {10'd0, gy[2:0], gx[2:0]};
      ASEL_SENT:  raddr = cfg.sprite_table_base + {6'd0, spr, cmd.ent};
      ASEL_SPIX:  raddr = cfg.sprite_tile_base + {pix_prod, 6'd0} +
                          {1'b0, row_ofs, 3'd0} + {9'd0, col};
      default:    raddr = '0;
    endcase
  end

  assign cell_mul  = gy[7:3] * (17'(GRID_COLS) + {1'b0, cfg.grid_row_skip});
  assign prod_full = tile_lo * wh;
  assign col_c     = hflip ? ({wn, 3'b111} - lx[6:0]) : lx[6:0];
  assign row_c     = vflip ? ({hn, 3'b111} - ly[6:0]) : ly[6:0];
  assign row_mul   = row_c * ({1'b0, wn} + 5'd1);
  assign sx_ext    = {{3{rd_data[31]}}, rd_data};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px        <= in_item.pixel_x;
      py        <= in_item.pixel_y;
      gx        <= {25'd0, in_item.pixel_x} + {{2{cfg.scroll_x[31]}}, cfg.scroll_x};
      gy        <= {26'd0, in_item.pixel_y} + {{2{cfg.scroll_y[31]}}, cfg.scroll_y};
      offscreen <= (in_item.pixel_x >= 9'(SCREEN_W)) || (in_item.pixel_y >= 8'(SCREEN_H));
      acc       <= cfg.clear_color;
    end
    if (cmd.mul) begin
      cell_ofs <= cell_mul[15:0];
    end
    if (cmd.spr_clr) begin
      spr <= '0;
    end else if (cmd.spr_inc) begin
      spr <= spr + 1'b1;
    end
    if (cmd.cap_status) begin
      wn    <= rd_data[11:8];
      hn    <= rd_data[15:12];
      hflip <= rd_data[16];
      vflip <= rd_data[17];
      wh    <= {5'd0, rd_data[11:8]} + 9'd1;
    end
    if (cmd.cap_tile) begin
      tile_lo <= rd_data[9:0];
      wh      <= 9'(wh * ({5'd0, hn} + 9'd1));
    end
    if (cmd.cap_x) begin
      lx <= {gx[33], gx} - sx_ext;
    end
    if (cmd.cap_y) begin
      ly <= {gy[33], gy} - sx_ext;
    end
    if (cmd.cap_pix) begin
      pix_prod <= prod_full[9:0];
      row_ofs  <= row_mul;
      col      <= col_c;
    end
    if (cmd.apply && (rd_data[31:24] == 8'hFF)) begin
      acc <= rd_data;
    end
    if (cmd.out_load) begin
      out_item.color <= acc;
      out_item.out_x <= px;
      out_item.out_y <= py;
    end
  end

  assign stat.offscreen = offscreen;
  assign stat.grid_ok   = !gx[33] && !gy[33] && (gx < 34'(GRID_PIX_W)) &&
                          (gy < 34'(GRID_PIX_H));
  assign stat.cell_ok   = !rd_data[31] && (rd_data[30] == cmd.front);
  assign stat.spr_en    = rd_data[0];
  assign stat.spr_hit   = !lx[34] && !ly[34] &&
                          (lx < {27'd0, {1'b0, wn} + 5'd1, 3'd0}) &&
                          (ly < {27'd0, {1'b0, hn} + 5'd1, 3'd0});
  assign stat.spr_last  = (spr == SPR_W'(SPRITE_COUNT - 1));
endmodule

>>> src/tspc_ctrl.sv
// Controller: sequences grid, sprite and front-grid passes of one pixel query.
// Depends on tspc_pkg and the assertion macro header.
`include "tile_sprite_pixel_compositor_defines.svh"
module tspc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tspc_pkg::in_item_t in_item,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tspc_pkg::stat_t    stat,
  output tspc_pkg::cmd_t     cmd
);
  import tspc_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_GMUL   = 4'd2;
  localparam logic [3:0] ST_GCELL  = 4'd3;
  localparam logic [3:0] ST_GTILE  = 4'd4;
  localparam logic [3:0] ST_GAPPLY = 4'd5;
  localparam logic [3:0] ST_SRD0   = 4'd6;
  localparam logic [3:0] ST_SRD1   = 4'd7;
  localparam logic [3:0] ST_SRD2   = 4'd8;
  localparam logic [3:0] ST_SRD3   = 4'd9;
  localparam logic [3:0] ST_SY     = 4'd10;
  localparam logic [3:0] ST_SCHK   = 4'd11;
  localparam logic [3:0] ST_SPIX   = 4'd12;
  localparam logic [3:0] ST_SAPPLY = 4'd13;
  localparam logic [3:0] ST_SNEXT  = 4'd14;
  localparam logic [3:0] ST_DONE   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       front;
  logic       front_next;
  logic       accept;
  logic       out_busy;
  logic [3:0] grid_exit;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;
  assign grid_exit = front ? ST_DONE : ST_SRD0;

  always_comb begin
    cmd        = '0;
    cmd.front  = front;
    state_next = state;
    front_next = front;
    case (state)
      ST_IDLE: begin
        cmd.wr_en = accept && (in_item.opcode == OP_WRITE);
        cmd.start = accept && (in_item.opcode == OP_QUERY);
        if (cmd.start) begin
          state_next = ST_START;
          front_next = 1'b0;
        end
      end
      ST_START: begin
        cmd.spr_clr = 1'b1;
        state_next  = stat.offscreen ? ST_DONE : ST_GMUL;
      end
      ST_GMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_GCELL;
      end
      ST_GCELL: begin
        cmd.asel = ASEL_CELL;
        if (stat.grid_ok) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_GTILE;
        end else begin
          state_next = grid_exit;
        end
      end
      ST_GTILE: begin
        cmd.asel = ASEL_GTILE;
        if (stat.cell_ok) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_GAPPLY;
        end else begin
          state_next = grid_exit;
        end
      end
      ST_GAPPLY: begin
        cmd.apply  = 1'b1;
        state_next = grid_exit;
      end
      ST_SRD0: begin
        cmd.rd_en  = 1'b1;
        cmd.asel   = ASEL_SENT;
        cmd.ent    = ENT_STATUS;
        state_next = ST_SRD1;
      end
      ST_SRD1: begin
        cmd.rd_en      = 1'b1;
        cmd.asel       = ASEL_SENT;
        cmd.ent        = ENT_TILE;
        cmd.cap_status = 1'b1;
        state_next     = stat.spr_en ? ST_SRD2 : ST_SNEXT;
      end
      ST_SRD2: begin
        cmd.rd_en    = 1'b1;
        cmd.asel     = ASEL_SENT;
        cmd.ent      = ENT_X;
        cmd.cap_tile = 1'b1;
        state_next   = ST_SRD3;
      end
      ST_SRD3: begin
        cmd.rd_en  = 1'b1;
        cmd.asel   = ASEL_SENT;
        cmd.ent    = ENT_Y;
        cmd.cap_x  = 1'b1;
        state_next = ST_SY;
      end
      ST_SY: begin
        cmd.cap_y  = 1'b1;
        state_next = ST_SCHK;
      end
      ST_SCHK: begin
        cmd.cap_pix = 1'b1;
        state_next  = stat.spr_hit ? ST_SPIX : ST_SNEXT;
      end
      ST_SPIX: begin
        cmd.rd_en  = 1'b1;
        cmd.asel   = ASEL_SPIX;
        state_next = ST_SAPPLY;
      end
      ST_SAPPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SNEXT;
      end
      ST_SNEXT: begin
        if (stat.spr_last) begin
          front_next = 1'b1;
          state_next = ST_GCELL;
        end else begin
          cmd.spr_inc = 1'b1;
          state_next  = ST_SRD0;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TSPC_ASSERT_NEXT(a_query_starts, clk, rst, cmd.start, state == ST_START)
  `TSPC_ASSERT_NEXT(a_load_shows, clk, rst, cmd.out_load, out_valid && state == ST_IDLE)
  `TSPC_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, !out_busy)
  `TSPC_ASSERT_SAME(a_write_idle, clk, rst, cmd.wr_en, !cmd.rd_en && state == ST_IDLE)
  `TSPC_ASSERT_NEXT(a_front_pass, clk, rst, state == ST_SNEXT && stat.spr_last,
                    front && state == ST_GCELL)
endmodule

>>> tb/tile_sprite_pixel_compositor_tb.sv
// Self-checking testbench for tile_sprite_pixel_compositor.
// Depends on tspc_pkg and the compositor RTL; predicts every pixel query in-house.
`timescale 1ns / 1ps

module tile_sprite_pixel_compositor_tb;
  import tspc_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 10000;
  localparam int ITEMS_PER_PASS = 135;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tile_sprite_pixel_compositor u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's memory and registers, kept in step with accepted transfers.
  bit [31:0] shadow_mem [MEM_WORDS];
  bit [31:0] sh_clear;
  bit [15:0] sh_gbase, sh_gskip, sh_gtile, sh_stable, sh_stile;
  longint    sh_scroll_x, sh_scroll_y;

  in_item_t  pending_items [$];
  out_item_t expected_pixels [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic bit [31:0] mem_at(longint a);
    longint r;
    r = a % MEM_WORDS;
    if (r < 0) r += MEM_WORDS;
    return shadow_mem[r];
  endfunction

  function automatic bit [31:0] paint(bit [31:0] acc, bit [31:0] c);
    return (c[31:24] == 8'hFF) ? c : acc;
  endfunction

  function automatic bit [31:0] grid_pass(longint x, longint y, bit front, bit [31:0] acc);
    longint gx, gy, cx, cy;
    bit [31:0] cell_word;
    gx = x + sh_scroll_x;
    gy = y + sh_scroll_y;
    if (gx < 0 || gy < 0) return acc;
    cx = gx / 8;
    cy = gy / 8;
    if (cx >= GRID_COLS || cy >= GRID_ROWS) return acc;
    cell_word = mem_at(longint'(sh_gbase) + cy * (GRID_COLS + longint'(sh_gskip)) + cx);
    if (cell_word[31] || cell_word[30] != front) return acc;
    return paint(acc, mem_at(longint'(sh_gtile) + longint'(cell_word[29:0]) * 64
                             + (gy % 8) * 8 + (gx % 8)));
  endfunction

  // Compose one pixel: clear color, back grid, sprites in table order, front grid.
  function automatic bit [31:0] compose_pixel(bit [8:0] px, bit [7:0] py);
    bit [31:0] acc, status;
    longint x, y, ent, tile, sx, sy, w, h, lx, ly, col, row;
    acc = sh_clear;
    if (px >= SCREEN_W || py >= SCREEN_H) return acc;
    x = px;
    y = py;
    acc = grid_pass(x, y, 1'b0, acc);
    for (int s = 0; s < SPRITE_COUNT; s++) begin
      ent = longint'(sh_stable) + 4 * s;
      status = mem_at(ent);
      if (!status[0]) continue;
      tile = longint'(signed'(mem_at(ent + 1)));
      sx = longint'(signed'(mem_at(ent + 2))) - sh_scroll_x;
      sy = longint'(signed'(mem_at(ent + 3))) - sh_scroll_y;
      w = (longint'(status[11:8]) + 1) * 8;
      h = (longint'(status[15:12]) + 1) * 8;
      lx = x - sx;
      ly = y - sy;
      if (lx < 0 || lx >= w || ly < 0 || ly >= h) continue;
      col = status[16] ? (w - 1 - lx) : lx;
      row = status[17] ? (h - 1 - ly) : ly;
      acc = paint(acc, mem_at(longint'(sh_stile) + tile * w * h + row * w + col));
    end
    return grid_pass(x, y, 1'b1, acc);
  endfunction

  // Sender: hold the payload while stalled, advance on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: update the shadow on input transfers, check each output transfer.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (in_item.opcode == OP_WRITE) begin
          shadow_mem[in_item.address] = in_item.write_data;
        end else begin
          want.color = compose_pixel(in_item.pixel_x, in_item.pixel_y);
          want.out_x = in_item.pixel_x;
          want.out_y = in_item.pixel_y;
          expected_pixels.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel: color=%h x=%0d y=%0d",
                     out_item.color, out_item.out_x, out_item.out_y);
        end else begin
          want = expected_pixels.pop_front();
          if (out_item.color !== want.color || out_item.out_x !== want.out_x ||
              out_item.out_y !== want.out_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: exp color=%h x=%0d y=%0d, got color=%h x=%0d y=%0d",
                       want.color, want.out_x, want.out_y,
                       out_item.color, out_item.out_x, out_item.out_y);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_write(bit [15:0] addr, bit [31:0] data);
    in_item_t it;
    it = '0;
    it.opcode = OP_WRITE;
    it.address = addr;
    it.write_data = data;
    it.pixel_x = 9'($urandom);
    it.pixel_y = 8'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_query(bit [8:0] x, bit [7:0] y);
    in_item_t it;
    it.opcode = OP_QUERY;
    it.address = 16'($urandom);
    it.write_data = $urandom;
    it.pixel_x = x;
    it.pixel_y = y;
    pending_items.push_back(it);
  endtask

  // Write one sprite table entry: status, tile, x, y.
  task automatic put_sprite(int slot, bit [31:0] status, bit [31:0] tile,
                            bit [31:0] x, bit [31:0] y);
    bit [15:0] ent;
    ent = sh_stable + 16'(4 * slot);
    push_write(ent, status);
    push_write(ent + 16'd1, tile);
    push_write(ent + 16'd2, x);
    push_write(ent + 16'd3, y);
  endtask

  // Register write with setup and access phases; update the shadow register at the same time.
  task automatic reg_write(logic [2:0] idx, bit [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CLEAR:   sh_clear = value;
      REG_GBASE:   sh_gbase = value[15:0];
      REG_GSKIP:   sh_gskip = value[15:0];
      REG_GTILE:   sh_gtile = value[15:0];
      REG_STABLE:  sh_stable = value[15:0];
      REG_STILE:   sh_stile = value[15:0];
      REG_SCROLLX: sh_scroll_x = longint'(signed'(value));
      REG_SCROLLY: sh_scroll_y = longint'(signed'(value));
      default: ;
    endcase
  endtask

  // Wait for the queue to drain and every pixel to arrive; writes leave no trace, so pad.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic bit [31:0] random_status();
    bit [31:0] st;
    st = $urandom & 32'hFFFC_0000;
    st[0] = 1'b1;
    st[11:8] = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
    st[15:12] = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
    st[16] = 1'($urandom);
    st[17] = 1'($urandom);
    return st;
  endfunction

  // Random pass: mostly placed sprites and grid cells followed by queries, plus noise.
  task automatic random_pass(int count);
    int n, pick;
    bit [31:0] cell_word;
    bit [15:0] caddr;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        put_sprite($urandom_range(SPRITE_COUNT - 1), random_status(),
                   ($urandom_range(7) == 0) ? $urandom : $urandom_range(63),
                   32'(sh_scroll_x) + 32'($urandom_range(449)) - 32'd130,
                   32'(sh_scroll_y) + 32'($urandom_range(369)) - 32'd130);
        push_query(9'($urandom_range(SCREEN_W - 1)), 8'($urandom_range(SCREEN_H - 1)));
        push_query(9'($urandom_range(SCREEN_W - 1)), 8'($urandom_range(SCREEN_H - 1)));
        n += 6;
      end else if (pick < 50) begin
        cell_word = $urandom_range(255);
        cell_word[30] = 1'($urandom);
        cell_word[31] = ($urandom_range(4) == 0);
        caddr = sh_gbase + 16'($urandom_range(GRID_ROWS - 1) * (GRID_COLS + sh_gskip)
                               + $urandom_range(GRID_COLS - 1));
        push_write(caddr, cell_word);
        push_query(9'($urandom_range(SCREEN_W - 1)), 8'($urandom_range(SCREEN_H - 1)));
        n += 2;
      end else if (pick < 55) begin
        push_write(16'($urandom), $urandom);
        n += 1;
      end else if (pick < 62) begin
        push_query(9'($urandom_range(511)), 8'($urandom_range(255)));
        n += 1;
      end else begin
        push_query(9'($urandom_range(SCREEN_W - 1)), 8'($urandom_range(SCREEN_H - 1)));
        n += 1;
      end
    end
  endtask

  initial begin
    bit [31:0] fill;
    sh_clear = '0; sh_gbase = '0; sh_gskip = '0; sh_gtile = '0;
    sh_stable = '0; sh_stile = '0; sh_scroll_x = 0; sh_scroll_y = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill all of memory first so no query ever touches a word never written.
    // Half the words are opaque colors so layers actually paint.
    for (int a = 0; a < MEM_WORDS; a++) begin
      fill = $urandom;
      if ($urandom_range(1)) fill[31:24] = 8'hFF;
      push_write(16'(a), fill);
    end
    drain();

    // Directed: field extremes, flips, off-screen pixels, empty and front cells.
    push_write(16'h0000, 32'h0000_0000);
    push_write(16'hFFFF, 32'hFFFF_FFFF);
    put_sprite(0, 32'h0000_3301, 32'd0, 32'd0, 32'd0);
    put_sprite(1, 32'h0001_1101, 32'd1, 32'd300, 32'd220);
    put_sprite(2, 32'h0002_0001, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'd230);
    put_sprite(3, 32'h0003_FF01, 32'd2, 32'd200, 32'd100);
    push_write(sh_gbase, 32'h8000_0000);
    push_write(sh_gbase + 16'd1, 32'h4000_0003);
    push_query(9'd0, 8'd0);
    push_query(9'd8, 8'd0);
    push_query(9'd319, 8'd239);
    push_query(9'd0, 8'd239);
    push_query(9'd320, 8'd0);
    push_query(9'd0, 8'd240);
    push_query(9'd511, 8'd255);
    push_query(9'd250, 8'd150);

    // No idling; long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_trigger++;
    random_pass(ITEMS_PER_PASS - 24);
    drain();

    // Opaque clear color, spread-out bases, sender idle.
    reg_write(REG_CLEAR, 32'hFFFF_FFFF);
    reg_write(REG_GBASE, $urandom);
    reg_write(REG_GSKIP, $urandom_range(40));
    reg_write(REG_GTILE, $urandom);
    reg_write(REG_STABLE, $urandom);
    reg_write(REG_STILE, $urandom);
    reg_write(REG_SCROLLX, 32'd0);
    reg_write(REG_SCROLLY, 32'd0);
    send_idle_pct = 53; recv_stall_pct = 0;
    random_pass(ITEMS_PER_PASS);
    drain();

    // Extreme registers: top of every base, maximal scroll; receiver stalls.
    reg_write(REG_CLEAR, 32'h00FF_FFFF);
    reg_write(REG_GBASE, 32'h0000_FFFF);
    reg_write(REG_GSKIP, 32'h0000_FFFF);
    reg_write(REG_GTILE, 32'h0000_FFFF);
    reg_write(REG_STABLE, 32'h0000_FFFF);
    reg_write(REG_STILE, 32'h0000_FFFF);
    reg_write(REG_SCROLLX, 32'h7FFF_FFFF);
    reg_write(REG_SCROLLY, 32'h8000_0000);
    send_idle_pct = 0; recv_stall_pct = 53;
    random_pass(ITEMS_PER_PASS / 3);
    drain();
    reg_write(REG_SCROLLX, 32'h8000_0000);
    reg_write(REG_SCROLLY, 32'h7FFF_FFFF);
    random_pass(ITEMS_PER_PASS / 3);
    drain();

    // Small negative and positive scroll so the grid edges move; both sides idle.
    reg_write(REG_CLEAR, $urandom);
    reg_write(REG_GBASE, 32'd0);
    reg_write(REG_GSKIP, 32'd0);
    reg_write(REG_SCROLLX, 32'(-13));
    reg_write(REG_SCROLLY, 32'd21);
    send_idle_pct = 24; recv_stall_pct = 24;
    random_pass(ITEMS_PER_PASS);
    drain();

    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/tspc_pkg.sv
src/tspc_ram.sv
src/tspc_datapath.sv
src/tspc_ctrl.sv
src/tile_sprite_pixel_compositor.sv
tb/tile_sprite_pixel_compositor_tb.sv
